@@ hw/rtl/lgss_pkg.sv @@
// Package for the linear gradient span shader: shared constants, codes,
// controller state type and the command/status structs. No dependencies.
`timescale 1ns / 1ps
package lgss_pkg;

  localparam int MAX_STOPS_DEF = 8;
  localparam int MAX_SPAN_DEF  = 64;
  localparam int FRAC_BITS_DEF = 24;

  localparam int CFG_W   = 48;  // widest configuration register
  localparam int CFG_IW  = 3;   // configuration index width
  localparam int ACC_W   = 64;  // gradient parameter accumulator
  localparam int HALF_W  = 24;  // coefficient split for the start multiply
  localparam int CH_W    = 16;  // Q1.15 channel
  localparam int POS_W   = 12;
  localparam int LEN_W   = 7;
  localparam int IDX_W   = 3;
  localparam int IN_DATA_W = 104;
  localparam logic [CH_W-1:0] CH_ONE = 16'd32768;

  typedef enum logic [CFG_IW-1:0] {
    CFG_STEP_X,
    CFG_STEP_Y,
    CFG_OFFSET,
    CFG_STOP_COUNT,
    CFG_TILE_MODE
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TILE_CLAMP,
    TILE_REPEAT,
    TILE_MIRROR
  } tile_mode_e;

  typedef enum logic {
    OP_LOAD,
    OP_SHADE
  } opcode_e;

  typedef enum logic [1:0] {
    MUL_X_LO,
    MUL_X_HI,
    MUL_Y_LO,
    MUL_Y_HI
  } mul_step_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_INIT,
    ST_TILE,
    ST_READ,
    ST_MIX,
    ST_PREM,
    ST_PACK
  } ctrl_state_e;

  typedef struct packed {
    logic      wr_stop;
    logic      start;
    logic      mul;
    mul_step_e step;
    logic      init;
    logic      tile;
    logic      read;
    logic      mix;
    logic      prem;
    logic      pack;
    logic      last;
  } lgss_cmd_t;

  typedef struct packed {
    logic out_free;
  } lgss_sts_t;

endpackage

@@ hw/rtl/lgss_ctrl.sv @@
// Controller state machine of the gradient span shader.
// Depends on lgss_pkg; drives the datapath through lgss_cmd_t.
`timescale 1ns / 1ps
module lgss_ctrl import lgss_pkg::*; #(
  parameter int MAX_SPAN = MAX_SPAN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  opcode_e          opcode_i,
  input  logic [LEN_W-1:0] span_length_i,
  input  lgss_sts_t        sts_i,
  output lgss_cmd_t        cmd_o
);
  localparam int CW = $clog2(MAX_SPAN + 1);

  ctrl_state_e state_q, state_d;
  mul_step_e   step_q, step_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] len_clamped;
  logic          accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if ({1'b0, span_length_i} > (LEN_W + 1)'(MAX_SPAN)) begin
      len_clamped = CW'(MAX_SPAN);
    end else begin
      len_clamped = CW'(span_length_i);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && opcode_i == OP_SHADE && len_clamped != '0) begin
          state_d = ST_MUL;
          step_d  = MUL_X_LO;
          cnt_d   = len_clamped;
        end
      end
      ST_MUL: begin
        if (step_q == MUL_Y_HI) begin
          state_d = ST_INIT;
        end else begin
          step_d = mul_step_e'(step_q + 2'd1);
        end
      end
      ST_INIT: state_d = ST_TILE;
      ST_TILE: state_d = ST_READ;
      ST_READ: state_d = ST_MIX;
      ST_MIX:  state_d = ST_PREM;
      ST_PREM: state_d = ST_PACK;
      ST_PACK: begin
        if (sts_i.out_free) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = (cnt_q == CW'(1)) ? ST_IDLE : ST_TILE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o         = '0;
    cmd_o.step    = step_q;
    cmd_o.wr_stop = accept && opcode_i == OP_LOAD;
    cmd_o.start   = accept && opcode_i == OP_SHADE;
    cmd_o.mul     = (state_q == ST_MUL);
    cmd_o.init    = (state_q == ST_INIT);
    cmd_o.tile    = (state_q == ST_TILE);
    cmd_o.read    = (state_q == ST_READ);
    cmd_o.mix     = (state_q == ST_MIX);
    cmd_o.prem    = (state_q == ST_PREM);
    cmd_o.pack    = (state_q == ST_PACK) && sts_i.out_free;
    cmd_o.last    = (cnt_q == CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= MUL_X_LO;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_pack_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pack |-> sts_i.out_free) else $error("pack while output full");
  a_span_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PACK && cnt_q == CW'(1) && sts_i.out_free) |=> state_q == ST_IDLE)
    else $error("span did not end after last pixel");
  a_span_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == OP_SHADE && len_clamped != '0)
      |=> (state_q == ST_MUL && step_q == MUL_X_LO)) else $error("span start lost");
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_MUL && state_q != ST_INIT) |-> cnt_q != '0)
    else $error("pixel work with empty count");
`endif

endmodule

@@ hw/rtl/lgss_dp.sv @@
// Datapath of the gradient span shader: configuration registers, stop table,
// start multiply, tiling, interpolation, premultiply and output register. Uses lgss_pkg.
`timescale 1ns / 1ps
module lgss_dp import lgss_pkg::*; #(
  parameter int MAX_STOPS = MAX_STOPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic [IDX_W-1:0]  stop_index_i,
  input  logic [4*CH_W-1:0] stop_color_i,  // red, green, blue, alpha from high to low
  input  logic [POS_W-1:0]  span_x_i,
  input  logic [POS_W-1:0]  span_y_i,
  input  lgss_cmd_t         cmd_i,
  output lgss_sts_t         sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       out_data_o,
  output logic              out_last_o
);
  localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int NW = $clog2(MAX_STOPS + 1);
  localparam int UW = FRAC_BITS + 1;
  localparam int SW = UW + NW;
  localparam int VW = CH_W + UW + 1;
  localparam int KW = POS_W + 2;
  localparam logic [UW-1:0] ONE_U  = UW'(1) << FRAC_BITS;
  localparam logic [VW-1:0] HALF_V = VW'(1) << (FRAC_BITS - 1);

  // Configuration registers.
  logic signed [CFG_W-1:0] step_x_q, step_y_q, offset_q;
  logic [3:0]              stop_count_q;
  logic [1:0]              tile_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q     <= '0;
      step_y_q     <= '0;
      offset_q     <= '0;
      stop_count_q <= 4'd1;
      tile_mode_q  <= TILE_CLAMP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_X:     step_x_q     <= cfg_data_i;
        CFG_STEP_Y:     step_y_q     <= cfg_data_i;
        CFG_OFFSET:     offset_q     <= cfg_data_i;
        CFG_STOP_COUNT: stop_count_q <= cfg_data_i[3:0];
        CFG_TILE_MODE:  tile_mode_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Highest usable stop index, with zero and oversized counts folded in.
  logic [NW-1:0] n_m1;
  always_comb begin
    if (stop_count_q == 4'd0) begin
      n_m1 = '0;
    end else if ({1'b0, stop_count_q} > 5'(MAX_STOPS)) begin
      n_m1 = NW'(MAX_STOPS - 1);
    end else begin
      n_m1 = NW'({1'b0, stop_count_q} - 5'd1);
    end
  end

  // Stop color table.
  logic [4*CH_W-1:0] mem_q [MAX_STOPS];
  logic [4*CH_W-1:0] e1_q, e2_q;
  logic [NW-1:0]     k1_q, k2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_stop && (5'(stop_index_i) < 5'(MAX_STOPS))) begin
      mem_q[IW'(stop_index_i)] <= stop_color_i;
    end
    if (cmd_i.read) begin
      e1_q <= mem_q[k1_q[IW-1:0]];
      e2_q <= mem_q[k2_q[IW-1:0]];
    end
  end

  // Start value: a*(2x+1) + b*(2y+1) + 2c over four multiply steps.
  logic [KW-1:0]            kx_q, ky_q;
  logic signed [HALF_W:0]   mul_a;
  logic signed [KW-1:0]     mul_b;
  logic signed [HALF_W+KW:0] prod;
  logic signed [ACC_W-1:0]  prod_ext, term, base, acc_q, t_q;
  logic signed [ACC_W-1:0]  off2, sx_ext;
  logic                     hi_half;

  assign hi_half = (cmd_i.step == MUL_X_HI) || (cmd_i.step == MUL_Y_HI);

  always_comb begin
    unique case (cmd_i.step)
      MUL_X_LO: mul_a = $signed({1'b0, step_x_q[HALF_W-1:0]});
      MUL_X_HI: mul_a = $signed({step_x_q[CFG_W-1], step_x_q[CFG_W-1:HALF_W]});
      MUL_Y_LO: mul_a = $signed({1'b0, step_y_q[HALF_W-1:0]});
      default:  mul_a = $signed({step_y_q[CFG_W-1], step_y_q[CFG_W-1:HALF_W]});
    endcase
    mul_b    = (cmd_i.step == MUL_X_LO || cmd_i.step == MUL_X_HI) ?
               $signed(kx_q) : $signed(ky_q);
    prod     = mul_a * mul_b;
    prod_ext = {{(ACC_W - HALF_W - KW - 1){prod[HALF_W+KW]}}, prod};
    term     = hi_half ? (prod_ext <<< HALF_W) : prod_ext;
    off2     = {{(ACC_W - CFG_W - 1){offset_q[CFG_W-1]}}, offset_q, 1'b0};
    sx_ext   = {{(ACC_W - CFG_W){step_x_q[CFG_W-1]}}, step_x_q};
    base     = (cmd_i.step == MUL_X_LO) ? off2 : acc_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kx_q <= {1'b0, span_x_i, 1'b1};
      ky_q <= {1'b0, span_y_i, 1'b1};
    end
    if (cmd_i.mul) begin
      acc_q <= base + term;
    end
    if (cmd_i.init) begin
      t_q <= acc_q >>> 1;
    end else if (cmd_i.tile) begin
      t_q <= t_q + sx_ext;
    end
  end

  // Tiling into the unit range and scaling by the stop spacing.
  logic [UW-1:0]        m, u;
  logic [SW-1:0]        s;
  logic [SW-FRAC_BITS-1:0] k1_raw;
  logic [NW-1:0]        k1, k2;
  logic [FRAC_BITS-1:0] w_q;

  always_comb begin
    m = t_q[FRAC_BITS:0];
    unique case (tile_mode_q)
      TILE_CLAMP: begin
        if (t_q[ACC_W-1]) begin
          u = '0;
        end else if (t_q > (ACC_W'(1) <<< FRAC_BITS)) begin
          u = ONE_U;
        end else begin
          u = m;
        end
      end
      TILE_REPEAT: u = {1'b0, t_q[FRAC_BITS-1:0]};
      default:     u = (m > ONE_U) ? UW'(~m + UW'(1)) : m;
    endcase
    s      = SW'(u) * SW'(n_m1);
    k1_raw = s[SW-1:FRAC_BITS];
    k1     = (k1_raw > (SW - FRAC_BITS)'(n_m1)) ? n_m1 : NW'(k1_raw);
    k2     = (k1 < n_m1) ? NW'(k1 + NW'(1)) : n_m1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tile) begin
      k1_q <= k1;
      k2_q <= k2;
      w_q  <= s[FRAC_BITS-1:0];
    end
  end

  // Interpolation of the two stops, rounded and saturated per channel.
  logic [CH_W-1:0] ch_q [4];
  logic [CH_W-1:0] ch_d [4];
  logic [UW-1:0]   wbar;
  logic [VW-1:0]   v   [4];
  logic [VW-1:0]   rnd [4];

  always_comb begin
    wbar = ONE_U - {1'b0, w_q};
    for (int j = 0; j < 4; j++) begin
      v[j]   = VW'(e1_q[CH_W*(3-j) +: CH_W]) * VW'(wbar)
             + VW'(e2_q[CH_W*(3-j) +: CH_W]) * VW'({1'b0, w_q});
      rnd[j] = (v[j] + HALF_V) >> FRAC_BITS;
      ch_d[j] = (rnd[j] > VW'(CH_ONE)) ? CH_ONE : rnd[j][CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix) begin
      for (int j = 0; j < 4; j++) begin
        ch_q[j] <= ch_d[j];
      end
    end
  end

  // Premultiply: channel times alpha, then scale to eight bits.
  logic [24:0] a255;
  logic [7:0]  alpha8_q;
  logic [31:0] prem_q [3];
  logic [40:0] p255 [3];
  logic [7:0]  c8   [3];

  assign a255 = {1'b0, ch_q[3], 8'b0} - {9'b0, ch_q[3]} + 25'h0004000;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prem) begin
      alpha8_q <= a255[22:15];
      for (int j = 0; j < 3; j++) begin
        prem_q[j] <= ch_q[j] * ch_q[3];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      p255[j] = {1'b0, prem_q[j], 8'b0} - {9'b0, prem_q[j]} + (41'd1 << 29);
      c8[j]   = p255[j][37:30];
    end
  end

  // Output register.
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        out_last_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pack) begin
      out_data_q <= {alpha8_q, c8[0], c8[1], c8[2]};
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

`ifndef ASSERT_OFF
  a_rose_after_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.pack)) else $error("result without pack");
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.tile) |-> (k1_q <= n_m1 && k2_q <= n_m1 && k1_q <= k2_q))
    else $error("stop index out of range");
  a_single_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(cmd_i.tile) && n_m1 == '0) |-> w_q == '0)
    else $error("weight nonzero with one stop");
`endif

endmodule

@@ hw/rtl/linear_gradient_span_shader.sv @@
// Linear gradient span shader top level. A shade request first forms the start
// value (four multiply steps on one 25x14 multiplier, then a load), then works
// each pixel through tile, table read, mix, premultiply and pack. The pack step
// waits while the output register is full, and the next request is accepted only
// once the last pixel of the span is packed; a load leaves the controller idle.
// Reset (rst_ni, async, active low) clears control, config and output valid only.
`timescale 1ns / 1ps
module linear_gradient_span_shader import lgss_pkg::*; #(
  parameter int MAX_STOPS = MAX_STOPS_DEF,
  parameter int MAX_SPAN  = MAX_SPAN_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IW-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // stop_index[2:0], stop_red[18:3], stop_green[34:19], stop_blue[50:35],
  // stop_alpha[66:51], span_x[78:67], span_y[90:79], span_length[97:91], zero pad
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,   // opcode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // pixel_argb
  output logic                 m_axis_tlast    // span_last
);

  lgss_cmd_t cmd;
  lgss_sts_t sts;

  // The controller sequences one request at a time; the datapath holds the
  // configuration, the stop table and the output register, which lets the
  // next pixel be worked on while a finished one waits downstream.
  lgss_ctrl #(
    .MAX_SPAN (MAX_SPAN)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .opcode_i      (opcode_e'(s_axis_tuser)),
    .span_length_i (s_axis_tdata[97:91]),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // The stop table stores red in the top channel and alpha in the bottom one.
  lgss_dp #(
    .MAX_STOPS (MAX_STOPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .stop_index_i (s_axis_tdata[2:0]),
    .stop_color_i ({s_axis_tdata[18:3], s_axis_tdata[34:19],
                    s_axis_tdata[50:35], s_axis_tdata[66:51]}),
    .span_x_i     (s_axis_tdata[78:67]),
    .span_y_i     (s_axis_tdata[90:79]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule
